[hw/rtl/ffpa_pkg.sv]
// shared types and constants for the first-free part assigner
// no dependencies; imported by ffpa_ctrl, ffpa_dpath and the top level
package ffpa_pkg;

  localparam int VID_W   = 16;
  localparam int PART_W  = 6;
  localparam int CFG_W   = 7;
  localparam int ENTRY_W = PART_W + 1;
  localparam int STAT_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_NBR   = 2'd1;
  localparam logic [1:0] REQ_PLACE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NBR_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ASSIGNED = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [VID_W-1:0]  vertex_id;
    logic [PART_W-1:0] load_part;
  } in_item_t;

  typedef struct packed {
    logic [VID_W-1:0]  placed_vertex;
    logic [PART_W-1:0] chosen_part;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } fsm_state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic rd_en;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_place;
    logic out_free;
  } ctrl_sts_t;

endpackage

[hw/rtl/ffpa_ctrl.sv]
// controller state machine for the first-free part assigner
// depends on ffpa_pkg; drives commands into ffpa_dpath
module ffpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffpa_pkg::ctrl_sts_t sts,
  output ffpa_pkg::ctrl_cmd_t cmd
);
  import ffpa_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // a place waits until the result register can take its result
        if (!sts.is_place || sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

[hw/rtl/ffpa_dpath.sv]
// datapath for the first-free part assigner: table memory, occupancy mask,
// first-free encoder, config register and result register; depends on ffpa_pkg
module ffpa_dpath #(
  parameter int MAX_VERTICES = 65536,
  parameter int MAX_PARTS    = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffpa_pkg::ctrl_cmd_t cmd,
  output ffpa_pkg::ctrl_sts_t sts,
  input  ffpa_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic [ffpa_pkg::CFG_W-1:0] cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffpa_pkg::out_item_t out_data
);
  import ffpa_pkg::*;

  localparam int TABLE_DEPTH = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam logic [MAX_PARTS-1:0] MASK_ONE = {{(MAX_PARTS-1){1'b0}}, 1'b1};
  localparam logic [CFG_W-1:0]     K_MAX    = CFG_W'(MAX_PARTS);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  in_item_t           item_r;
  logic [ENTRY_W-1:0] rd_r;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic [CFG_W-1:0]   parts_r;
  logic [MAX_PARTS-1:0] mask_r, mask_nxt;
  logic               miss_r, miss_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  logic [ENTRY_W-1:0]   entry;
  logic [CFG_W-1:0]     k_eff;
  logic [MAX_PARTS-1:0] allowed, free_v, lowest;
  logic                 found;
  logic [PART_W-1:0]    enc;
  out_item_t            res;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic                 place_fire, load_ok;

  assign idx      = item_r.vertex_id[IDX_W-1:0];
  assign in_range = (32'(item_r.vertex_id) < 32'(MAX_VERTICES));
  assign entry    = in_range ? rd_r : '0;
  assign k_eff    = (parts_r > K_MAX) ? K_MAX : parts_r;

  // first free part: isolate lowest clear bit below k, then encode
  always_comb begin
    for (int i = 0; i < MAX_PARTS; i++) begin
      allowed[i] = (CFG_W'(i) < k_eff);
    end
    free_v = ~mask_r & allowed;
    found  = |free_v;
    lowest = free_v & (~free_v + MASK_ONE);
    enc    = '0;
    for (int i = 0; i < MAX_PARTS; i++) begin
      if (lowest[i]) begin
        enc = enc | PART_W'(i);
      end
    end
  end

  always_comb begin
    res.placed_vertex = item_r.vertex_id;
    res.chosen_part   = '0;
    if (entry[PART_W] || !in_range) begin
      res.status = STAT_ASSIGNED;
    end else if (!found) begin
      res.status = STAT_NO_FREE;
    end else begin
      res.chosen_part = enc;
      res.status      = miss_r ? STAT_NBR_MISS : STAT_OK;
    end
  end

  assign place_fire = cmd.exec && (item_r.req_type == REQ_PLACE);
  assign load_ok    = cmd.exec && (item_r.req_type == REQ_LOAD) && in_range &&
                      ({1'b0, item_r.load_part} < k_eff);

  // table write port: clearing pass, loads and successful places
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {1'b1, item_r.load_part};
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else if (load_ok) begin
      we = 1'b1;
    end else if (place_fire &&
                 (res.status == STAT_OK || res.status == STAT_NBR_MISS)) begin
      we    = 1'b1;
      wdata = {1'b1, enc};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    miss_nxt = miss_r;
    if (cmd.exec && item_r.req_type == REQ_NBR) begin
      if (entry[PART_W]) begin
        mask_nxt = mask_r | (MASK_ONE << entry[PART_W-1:0]);
      end else begin
        miss_nxt = 1'b1;
      end
    end else if (place_fire) begin
      mask_nxt = '0;
      miss_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      parts_r     <= CFG_RESET;
      mask_r      <= '0;
      miss_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_valid) begin
        parts_r <= cfg_data;
      end
      mask_r <= mask_nxt;
      miss_r <= miss_nxt;
      if (place_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (place_fire) begin
      out_item_r <= res;
    end
  end

  assign sts.clr_last = (clr_cnt_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.is_place = (item_r.req_type == REQ_PLACE);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

[hw/rtl/first_free_part_assigner.sv]
// top level of the first-free part assigner (greedy first-fit coloring)
// depends on ffpa_pkg, ffpa_ctrl and ffpa_dpath
//
// Keeps a part number (or "unassigned") for each vertex in an on-chip table
// of min(MAX_VERTICES, 65536) entries. Load transfers preload a vertex's part
// (ignored when the part is not below parts_in_use or the vertex is out of
// range), neighbour transfers mark the neighbour's part in an occupancy mask,
// and a place transfer gives its vertex the lowest free part below
// parts_in_use, emits one result and clears the mask. Each item passes in
// turn through the transfer itself, the registered table read, and the
// update of the table, mask or result register; no new item is taken until
// the last one is done. A place item holds in its update step while a
// previous result is still stalled in the output register. After reset the
// table is swept to unassigned, one entry per cycle, and no input is taken
// until the sweep is done; config writes are always taken.
// The parts_in_use register resets to 2 and is meant to be written only
// while the block is idle.
module first_free_part_assigner #(
  parameter int MAX_VERTICES = 65536,
  parameter int MAX_PARTS    = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // input item channel
  input  logic                in_valid,
  output logic                in_stall,
  input  ffpa_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output ffpa_pkg::out_item_t out_data,
  // parts_in_use write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ffpa_pkg::CFG_W-1:0] cfg_data
);
  import ffpa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // register writes never wait
  assign cfg_ready = 1'b1;

  // sequencer: clearing pass, then accept / read / execute per item
  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, mask, first-free encoder and result register
  ffpa_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_PARTS    (MAX_PARTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[verif/testbench.sv]
// self-checking testbench for first_free_part_assigner
// depends on ffpa_pkg and the first_free_part_assigner rtl; needs no files or arguments
module testbench;
  import ffpa_pkg::*;

  // request code with no meaning, the block must drop it
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int POOL_N = 24;

  // tracks the vertex table and neighbour mask, queues the place results due
  class part_choice_board;
    bit [ENTRY_W-1:0] vertex_part [65536];  // msb set: assigned
    bit [63:0]        taken_parts;
    bit               nbr_missing;
    int unsigned      k_parts = 2;
    out_item_t        pending_places [$];
    int unsigned      errors;
    int unsigned      n_inputs;
    int unsigned      n_results;
    int unsigned      status_seen [4];

    function void set_parts(logic [CFG_W-1:0] v);
      k_parts = (v > 64) ? 64 : v;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function void note_item(in_item_t it);
      bit [ENTRY_W-1:0] entry;
      out_item_t want;
      bit found;
      int unsigned i;
      n_inputs++;
      entry = vertex_part[it.vertex_id];
      case (it.req_type)
        REQ_LOAD: begin
          if (it.load_part < k_parts) vertex_part[it.vertex_id] = {1'b1, it.load_part};
        end
        REQ_NBR: begin
          if (entry[PART_W]) taken_parts[entry[PART_W-1:0]] = 1'b1;
          else nbr_missing = 1'b1;
        end
        REQ_PLACE: begin
          found = 1'b0;
          want.placed_vertex = it.vertex_id;
          want.chosen_part = '0;
          for (i = 0; i < k_parts; i++) begin
            if (!taken_parts[i]) begin
              want.chosen_part = i[PART_W-1:0];
              found = 1'b1;
              break;
            end
          end
          if (entry[PART_W]) begin
            want.status = STAT_ASSIGNED;
            want.chosen_part = '0;
          end else if (!found) begin
            want.status = STAT_NO_FREE;
            want.chosen_part = '0;
          end else begin
            vertex_part[it.vertex_id] = {1'b1, want.chosen_part};
            want.status = nbr_missing ? STAT_NBR_MISS : STAT_OK;
          end
          pending_places.push_back(want);
          taken_parts = '0;
          nbr_missing = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (pending_places.size() == 0) begin
        report($sformatf("unexpected result vertex %h part %0d status %0d",
                         got.placed_vertex, got.chosen_part, got.status));
      end else begin
        want = pending_places[0];
        pending_places.delete(0);
        status_seen[want.status]++;
        if (got.placed_vertex !== want.placed_vertex)
          report($sformatf("placed_vertex %h, want %h", got.placed_vertex, want.placed_vertex));
        if (got.chosen_part !== want.chosen_part)
          report($sformatf("vertex %h chosen_part %0d, want %0d", want.placed_vertex,
                           got.chosen_part, want.chosen_part));
        if (got.status !== want.status)
          report($sformatf("vertex %h status %0d, want %0d", want.placed_vertex,
                           got.status, want.status));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  part_choice_board sb;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      n_settings = 0;
  logic [VID_W-1:0] vpool [POOL_N];

  first_free_part_assigner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side stalls at random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watch both channels, transfers seen with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin
    #4000000;
    $display("first_free_part_assigner test failed");
    $finish;
  end

  function automatic in_item_t mk(logic [1:0] kind, logic [VID_W-1:0] v,
                                  logic [PART_W-1:0] p);
    in_item_t it;
    it.req_type = kind;
    it.vertex_id = v;
    it.load_part = p;
    return it;
  endfunction

  // random sender gaps ahead of the item, then hold it until taken
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // let the last transfer land, wait for every result, then cover the item latency
  task automatic wait_quiet();
    int unsigned waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (sb.pending_places.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_parts(logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_parts(v);
    n_settings++;
  endtask

  function automatic logic [CFG_W-1:0] parts_for(int unsigned idx);
    case (idx % 8)
      0: return 7'd64;
      1: return 7'd2;
      2: return 7'd3;
      3: return 7'd0;
      4: return 7'd127;
      5: return 7'd1;
      6: return CFG_W'($urandom_range(64, 2));
      default: return CFG_W'($urandom_range(12, 4));
    endcase
  endfunction

  function automatic logic [PART_W-1:0] pick_part();
    if (sb.k_parts == 0 || $urandom_range(9) == 0) return PART_W'($urandom);
    return PART_W'($urandom_range(sb.k_parts - 1));
  endfunction

  // mostly neighbour runs closed by a place, plus loads and some noise
  task automatic run_segment(int unsigned n_items);
    int unsigned sent, roll, n_nbr, max_nbr, j;
    logic [VID_W-1:0] v;
    in_item_t it;
    sent = 0;
    foreach (vpool[p]) vpool[p] = VID_W'($urandom);
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        it = in_item_t'($urandom);
        send_item(it);
        if (it.req_type != REQ_UNUSED) sent++;
      end else if (roll < 30) begin
        send_item(mk(REQ_LOAD, vpool[$urandom_range(POOL_N - 1)], pick_part()));
        sent++;
      end else begin
        max_nbr = (sb.k_parts <= 8) ? sb.k_parts + 2 : 12;
        n_nbr = $urandom_range(max_nbr);
        for (j = 0; j < n_nbr; j++) begin
          v = ($urandom_range(99) < 85) ? vpool[$urandom_range(POOL_N - 1)]
                                        : VID_W'($urandom);
          send_item(mk(REQ_NBR, v, PART_W'($urandom)));
          sent++;
        end
        if ($urandom_range(99) < 75) begin
          v = VID_W'($urandom);
          vpool[$urandom_range(POOL_N - 1)] = v;
        end else begin
          v = vpool[$urandom_range(POOL_N - 1)];
        end
        send_item(mk(REQ_PLACE, v, PART_W'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned ph, sg;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, parts_in_use at its reset value of 2
    send_item(mk(REQ_LOAD, 16'h0000, 6'd0));
    send_item(mk(REQ_LOAD, 16'hffff, 6'd1));
    send_item(mk(REQ_LOAD, 16'h0005, 6'd2));     // part not below k, dropped
    send_item(mk(REQ_UNUSED, 16'h1234, 6'd63));  // unknown request, dropped
    send_item(mk(REQ_NBR, 16'h0000, 6'd0));
    send_item(mk(REQ_NBR, 16'hffff, 6'd0));
    send_item(mk(REQ_PLACE, 16'h0007, 6'd0));    // every part taken
    send_item(mk(REQ_PLACE, 16'h0000, 6'd0));    // vertex already holds a part
    send_item(mk(REQ_NBR, 16'h0009, 6'd0));      // neighbour not yet assigned
    send_item(mk(REQ_NBR, 16'h0000, 6'd0));
    send_item(mk(REQ_PLACE, 16'h0009, 6'd0));    // placed with missing neighbour
    send_item(mk(REQ_LOAD, 16'h0009, 6'd0));     // load overwrites a held part
    send_item(mk(REQ_NBR, 16'h0005, 6'd0));
    send_item(mk(REQ_PLACE, 16'hffff, 6'd0));    // assigned beats missing neighbour
    send_item(mk(REQ_PLACE, 16'h0003, 6'd0));    // mask was cleared, gets part 0
    wait_quiet();
    write_parts(7'd64);
    send_item(mk(REQ_LOAD, 16'h0100, 6'd63));
    send_item(mk(REQ_NBR, 16'h0100, 6'd0));
    send_item(mk(REQ_PLACE, 16'h0101, 6'd0));
    wait_quiet();
    write_parts(7'd0);
    send_item(mk(REQ_LOAD, 16'h0201, 6'd0));     // no part below zero, dropped
    send_item(mk(REQ_NBR, 16'h5000, 6'd0));
    send_item(mk(REQ_PLACE, 16'h0201, 6'd0));    // no free part beats missing
    send_item(mk(REQ_PLACE, 16'h0000, 6'd0));    // assigned beats no free part

    // random part over four idle/stall mixes, several parts_in_use values each
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 81;
        end
        default: begin
          send_idle_pct = 7;
          stall_pct = 7;
        end
      endcase
      for (sg = 0; sg < 4; sg++) begin
        wait_quiet();
        write_parts(parts_for(ph * 4 + sg));
        run_segment(120);
      end
    end
    wait_quiet();
    if (sb.pending_places.size() != 0)
      sb.report($sformatf("%0d place results never arrived", sb.pending_places.size()));

    $display("covered %0d input transfers and %0d results over %0d parts_in_use settings",
             sb.n_inputs, sb.n_results, n_settings);
    $display("results by status: ok %0d, missing neighbour %0d, no free %0d, assigned %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_NBR_MISS],
             sb.status_seen[STAT_NO_FREE], sb.status_seen[STAT_ASSIGNED]);
    if (sb.errors == 0) begin
      $display("first_free_part_assigner test passed");
    end else begin
      $display("first_free_part_assigner test failed");
    end
    $finish;
  end
endmodule
